@@ rtl/srrw_pkg.sv @@
// shared types and constants for the selective-repeat receive window
`default_nettype none

package srrw_pkg;

    localparam int SEQ_W   = 16;
    localparam int COUNT_W = 4;
    localparam int CMP_W   = 33;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_num;
        logic             crc_ok;
    } t_in_word;

    typedef struct packed {
        logic [SEQ_W-1:0]   ack_id;
        logic               nack;
        logic               discarded;
        logic [COUNT_W-1:0] delivered_count;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctl_cmd;

endpackage

`default_nettype wire

@@ rtl/selective_repeat_receive_window_top.sv @@
// top level of the selective-repeat receive window
// usage:
//   input channel i_in_valid / o_in_ready carries one frame word: sequence
//   number and crc flag. output channel o_out_valid / i_out_ready carries
//   one result word per frame: ack id, nack, discarded flag, delivered count.
//   i_cfg_we / i_cfg_wdata writes the hamming mode bit (1 = all frames valid);
//   write it only while no frame is in flight.
//   a frame is taken in the capture step of the controller and its result is
//   written to the output register when the evaluate step commits; the bitmap
//   slide is done in the evaluate step. no new frame is taken until it commits.
//   the result sits in an output register, so a new frame is taken while a
//   result still waits; if the receiver stalls, the next frame waits in the
//   evaluate step until the output register frees up, and input ready drops.
//   reset (synchronous, active low) clears the window base, the bitmap, the
//   hamming mode bit and the output valid flag and holds input ready low;
//   no clearing pass is needed.
`default_nettype none

module selective_repeat_receive_window_top #(
    parameter int WINDOW_SIZE = 8,
    parameter int SEQ_BITS    = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  srrw_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output srrw_pkg::t_out_word o_out_word
);
    import srrw_pkg::*;

    t_ctl_cmd cmd;

    srrw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    srrw_dpath #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SEQ_BITS    (SEQ_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

@@ rtl/srrw_ctrl.sv @@
// controller: input capture, evaluation step and output register handshake
`default_nettype none

module srrw_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output srrw_pkg::t_ctl_cmd o_cmd
);
    import srrw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_commit_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (r_state == S_EVAL))
        else $error("commit outside evaluation state");

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EVAL))
        else $error("accepted word not evaluated next cycle");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_cmd.commit)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/srrw_dpath.sv @@
// datapath: window base, receive bitmap, slide logic and result register
`default_nettype none

module srrw_dpath #(
    parameter int WINDOW_SIZE = 8,
    parameter int SEQ_BITS    = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_wdata,
    input  srrw_pkg::t_in_word  i_in_word,
    input  srrw_pkg::t_ctl_cmd  i_cmd,
    output srrw_pkg::t_out_word o_out_word
);
    import srrw_pkg::*;

    localparam int WS = WINDOW_SIZE;
    localparam int SW = SEQ_BITS;
    localparam int IW = (WS > 1) ? $clog2(WS) : 1;
    localparam int CW = $clog2(WS + 1);
    localparam logic [SW-1:0] SEQ_MAX = '1;

    logic             r_mode;
    logic [SEQ_W-1:0] r_seq;
    logic             r_valid;
    logic [SW-1:0]    r_base, n_base;
    logic [WS-1:0]    r_map, n_map;
    t_out_word        r_out, n_out;

    logic [SW-1:0]  seq_m;
    logic [SW-1:0]  off;
    logic [IW-1:0]  idx;
    logic [WS-1:0]  onehot;
    logic           stale, beyond, dup, disc, at_base, slide, mark_ahead;
    logic [WS-1:0]  m;
    logic [WS:0]    m_ext, first_zero;
    logic [CW-1:0]  ones, n_slide;
    logic [SW-1:0]  limit;
    logic [COUNT_W-1:0] count;

    always_comb begin
        seq_m  = SW'(r_seq);
        stale  = seq_m < r_base;
        off    = seq_m - r_base;
        beyond = CMP_W'(off) >= CMP_W'(WS);
        idx    = IW'(off);
        onehot = WS'(1) << idx;
        dup    = |(r_map & onehot);
        disc   = stale | beyond | dup;
        at_base    = (off == '0);
        slide      = !disc && at_base && r_valid;
        mark_ahead = !disc && !at_base && r_valid;
    end

    // trailing ones of the marked map, limited by room left below the top
    always_comb begin
        m          = r_map | WS'(1);
        m_ext      = {1'b0, m};
        first_zero = (m_ext + (WS+1)'(1)) & ~m_ext;
        ones       = '0;
        for (int i = 0; i <= WS; i++) begin
            if (first_zero[i]) begin
                ones = ones | CW'(i);
            end
        end
        limit = SEQ_MAX - r_base;
        if (CMP_W'(ones) < CMP_W'(limit)) begin
            n_slide = ones;
        end else begin
            n_slide = CW'(limit);
        end
        if (CMP_W'(n_slide) > CMP_W'(15)) begin
            count = 4'd15;
        end else begin
            count = COUNT_W'(n_slide);
        end
    end

    always_comb begin
        n_base = r_base;
        n_map  = r_map;
        if (slide) begin
            n_base = r_base + SW'(n_slide);
            n_map  = m >> n_slide;
        end else if (mark_ahead) begin
            n_map = r_map | onehot;
        end
        n_out.ack_id          = SEQ_W'(n_base);
        n_out.nack            = disc || !at_base || !r_valid;
        n_out.discarded       = disc;
        n_out.delivered_count = slide ? count : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_base <= '0;
            r_map  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_base <= n_base;
                r_map  <= n_map;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_seq   <= i_in_word.seq_num;
            r_valid <= r_mode | i_in_word.crc_ok;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_word = r_out;

    a_base_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_base >= $past(r_base)))
        else $error("window base moved backward");

    a_stable_no_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit |=> ($stable(r_base) && $stable(r_map)))
        else $error("window state changed without commit");

    a_discard_nack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && disc |=> (r_out.nack && r_out.delivered_count == '0))
        else $error("discarded word without nack or with delivery");

endmodule

`default_nettype wire

@@ dv/selective_repeat_receive_window_top_tb.sv @@
// testbench for the selective-repeat receive window under random flow control
`timescale 1ns / 1ps

module selective_repeat_receive_window_top_tb;

    import srrw_pkg::*;

    localparam int WIN        = 8;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYC   = 200;
    localparam int DRAIN_CYC  = 6;

    typedef struct packed {
        logic [SEQ_W-1:0] base;
        logic [WIN-1:0]   rmap;
        logic             ham;
    } t_rx_win;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic      i_cfg_wdata;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    selective_repeat_receive_window_top #(
        .WINDOW_SIZE(WIN),
        .SEQ_BITS   (SEQ_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    t_in_word  frame_q[$];
    t_out_word expected_acks[$];
    t_rx_win   gen_win;
    t_rx_win   chk_win;

    logic in_took    = 1'b0;
    int   gap_left   = 0;
    int   burst_left = 1;
    int   burst_max  = 8;
    int   gap_max    = 4;
    int   rx_mode    = 1;
    int   stall_req  = 0;
    int   stall_seen = 0;
    int   hold_left  = 0;
    int   rx_run     = 0;
    logic rx_lvl     = 1'b1;
    int   idle_cnt   = 0;

    int err_cnt     = 0;
    int n_frames    = 0;
    int n_checked   = 0;
    int n_delivered = 0;
    int n_discarded = 0;
    int n_nacks     = 0;

    always #5 i_clk = ~i_clk;

    // window update: result word for one frame and the next window state
    function automatic t_out_word window_update(input t_rx_win cur, input t_in_word w,
                                                output t_rx_win nxt);
        t_rx_win   s;
        t_out_word r;
        logic      ok;
        int        off;
        int        cnt;
        s   = cur;
        r   = '0;
        cnt = 0;
        ok  = s.ham | w.crc_ok;
        if (w.seq_num < s.base) begin
            r.discarded = 1'b1;
            r.nack      = 1'b1;
        end else begin
            off = int'(w.seq_num) - int'(s.base);
            if (off >= WIN || s.rmap[off]) begin
                r.discarded = 1'b1;
                r.nack      = 1'b1;
            end else if (off == 0) begin
                if (ok) begin
                    s.rmap[0] = 1'b1;
                    while (s.rmap[0] && s.base != {SEQ_W{1'b1}}) begin
                        s.rmap = s.rmap >> 1;
                        s.base = s.base + 1'b1;
                        cnt++;
                    end
                end else begin
                    r.nack = 1'b1;
                end
            end else begin
                if (ok) s.rmap[off] = 1'b1;
                r.nack = 1'b1;
            end
        end
        r.ack_id          = s.base;
        r.delivered_count = (cnt > 15) ? 4'd15 : COUNT_W'(cnt);
        nxt = s;
        return r;
    endfunction

    function automatic void push_frame(input logic [SEQ_W-1:0] seq, input logic crc);
        t_in_word w;
        w.seq_num = seq;
        w.crc_ok  = crc;
        void'(window_update(gen_win, w, gen_win));
        frame_q.insert(frame_q.size(), w);
    endfunction

    // mostly frames around the current base, some stale, beyond or random
    function automatic void push_random(input int n);
        int   pick;
        int   rel;
        int   s;
        logic crc;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)      rel = $urandom_range(0, WIN - 1);
            else if (pick < 75) rel = -$urandom_range(1, 12);
            else                rel = $urandom_range(WIN, WIN + 12);
            s   = int'(gen_win.base) + rel;
            crc = ($urandom_range(0, 99) < 80);
            if (pick >= 85 || s < 0 || s > 65535) s = $urandom_range(0, 65535);
            push_frame(SEQ_W'(s), crc);
        end
    endfunction

    task automatic set_hamming(input logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_win.ham = v;
        chk_win.ham = v;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (frame_q.size() != 0 || i_in_valid || expected_acks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // sender: bursts of words with random gaps between them
    always @(negedge i_clk) begin : frame_driver
        logic     nxt_valid;
        t_in_word nxt_word;
        nxt_valid = i_in_valid;
        nxt_word  = i_in_word;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_in_valid || in_took) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (frame_q.size() > 0) begin
                nxt_word  = frame_q.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, burst_max);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_word  <= nxt_word;
    end

    // receiver: long hold-off on request, otherwise runs of ready and stall (always ready in mode 0)
    always @(negedge i_clk) begin : ack_sink
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (stall_req != stall_seen) begin
            stall_seen = stall_req;
            hold_left  = HOLD_CYC;
            nxt_ready  = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if (rx_mode != 0) begin
            if (rx_run == 0) begin
                rx_lvl = ~rx_lvl;
                if (rx_mode == 1)
                    rx_run = rx_lvl ? $urandom_range(1, 12) : $urandom_range(1, 3);
                else
                    rx_run = rx_lvl ? $urandom_range(1, 3) : $urandom_range(1, 10);
            end
            rx_run--;
            nxt_ready = rx_lvl;
        end
        i_out_ready <= nxt_ready;
    end

    // monitor: check each result word, then predict for each accepted frame
    always @(posedge i_clk) begin : ack_monitor
        t_out_word want;
        t_out_word got;
        in_took <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out_word;
            if (expected_acks.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result word: ack=%0d nack=%0b disc=%0b cnt=%0d",
                             got.ack_id, got.nack, got.discarded, got.delivered_count);
            end else begin
                want = expected_acks.pop_front();
                n_checked++;
                if (got.ack_id !== want.ack_id || got.nack !== want.nack ||
                    got.discarded !== want.discarded ||
                    got.delivered_count !== want.delivered_count) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch on result %0d: exp ack=%0d nack=%0b disc=%0b cnt=%0d",
                                 n_checked, want.ack_id, want.nack, want.discarded,
                                 want.delivered_count);
                        $display("    got ack=%0d nack=%0b disc=%0b cnt=%0d",
                                 got.ack_id, got.nack, got.discarded, got.delivered_count);
                    end
                end
                n_delivered += got.delivered_count;
                n_discarded += got.discarded;
                n_nacks     += got.nack;
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            want = window_update(chk_win, i_in_word, chk_win);
            expected_acks.insert(expected_acks.size(), want);
            n_frames++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("no word moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        gen_win     = '0;
        chk_win     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, crc checked
        set_hamming(1'b0);
        gap_max = 3;
        rx_mode = 1;
        push_frame(16'd0, 1'b0);
        push_frame(16'd3, 1'b1);
        push_frame(16'd3, 1'b1);
        push_frame(16'd5, 1'b0);
        push_frame(16'd8, 1'b1);
        push_frame(16'd7, 1'b1);
        push_frame(16'hFFFF, 1'b1);
        push_frame(16'd0, 1'b1);
        push_frame(16'd0, 1'b1);
        push_frame(16'd2, 1'b1);
        push_frame(16'd1, 1'b1);
        push_frame(16'd6, 1'b1);
        push_frame(16'd5, 1'b1);
        push_frame(16'd4, 1'b1);
        for (int s = 15; s >= 8; s--) push_frame(SEQ_W'(s), 1'b1);
        push_frame(16'h8000, 1'b0);
        wait_drained();

        // corrected frames
        set_hamming(1'b1);
        gap_max = 6;
        rx_mode = 2;
        push_frame(16'd16, 1'b0);
        push_frame(16'd18, 1'b0);
        push_frame(16'd17, 1'b0);
        push_random(150);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        set_hamming(1'b0);
        gap_max   = 0;
        burst_max = 64;
        rx_mode   = 1;
        stall_req = stall_req + 1;
        push_random(125);
        wait_drained();
        gap_max   = 10;
        burst_max = 8;
        rx_mode   = 0;
        push_random(125);
        wait_drained();

        set_hamming(1'b1);
        gap_max = 3;
        rx_mode = 2;
        push_random(200);
        wait_drained();

        set_hamming(1'b0);
        gap_max   = 5;
        burst_max = 8;
        rx_mode   = 1;
        push_random(60);
        wait_drained();

        $display("%0d frames sent, %0d result words checked, %0d errors", n_frames, n_checked,
                 err_cnt);
        $display("%0d frames delivered in order, %0d discarded, %0d nacks, final base %0d",
                 n_delivered, n_discarded, n_nacks, chk_win.base);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
